// ===== rtl/bomc_pkg.sv =====
// ----------------------------------------------------------------------------
// bomc_pkg
// Shared constants and types for the optimal-replacement miss counter.
// ----------------------------------------------------------------------------
package bomc_pkg;

	// default store sizes
	localparam int DEF_TRACE_DEPTH = 1024;
	localparam int DEF_MAX_ENTRIES = 64;

	// fixed field widths
	localparam int KEY_W   = 64;
	localparam int COUNT_W = 11;
	localparam int CAP_W   = 7;

	// capacity register after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd8;

	// answer of the cache unit for one trace word
	typedef struct packed {
		logic done;
		logic miss;
	} bomc_rsp_t;

endpackage

// ===== rtl/bomc_cache.sv =====
// ----------------------------------------------------------------------------
// bomc_cache
// Fully associative cache model: entry key and next-use memories, scanned one
// entry at a time (a read state, then a compare state), with farthest-next-use victim choice.
// ----------------------------------------------------------------------------
module bomc_cache #(
	parameter int MAX_ENTRIES = bomc_pkg::DEF_MAX_ENTRIES,
	parameter int LW          = 11,
	parameter int CW          = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic                       start,
	input  logic [bomc_pkg::KEY_W-1:0] key,
	input  logic [LW-1:0]              next_use,
	input  logic [CW-1:0]              capacity,
	output bomc_pkg::bomc_rsp_t        rsp
);

	localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_RD   = 4'b0010,
		C_EV   = 4'b0100,
		C_WR   = 4'b1000
	} cstate_t;

	cstate_t                      state_q;
	logic [bomc_pkg::KEY_W-1:0]   ekey_mem [MAX_ENTRIES];
	logic [LW-1:0]                enu_mem  [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]       valid_q;
	logic [bomc_pkg::KEY_W-1:0]   ekey_rd_q;
	logic [LW-1:0]                enu_rd_q;
	logic [bomc_pkg::KEY_W-1:0]   key_q;
	logic [LW-1:0]                nu_q;
	logic [CW-1:0]                e_q;
	logic                         hit_q;
	logic [EW-1:0]                hit_idx_q;
	logic                         free_q;
	logic [EW-1:0]                free_idx_q;
	logic                         have_v_q;
	logic [EW-1:0]                victim_q;
	logic [LW-1:0]                far_q;
	logic [EW-1:0]                e_idx;
	logic [EW-1:0]                wr_idx;
	logic                         mem_we;

	assign e_idx  = e_q[EW-1:0];
	assign wr_idx = free_q ? free_idx_q : victim_q;
	assign mem_we = (state_q == C_WR) && !hit_q;

	// entry memories: one read port, one write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ekey_mem[wr_idx] <= key_q;
		end
		if (state_q == C_WR) begin
			enu_mem[hit_q ? hit_idx_q : wr_idx] <= nu_q;
		end
		ekey_rd_q <= ekey_mem[e_idx];
		enu_rd_q  <= enu_mem[e_idx];
	end

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			valid_q <= '0;
			e_q     <= '0;
			rsp     <= '0;
		end else begin
			rsp.done <= (state_q == C_WR);
			rsp.miss <= (state_q == C_WR) && !hit_q;
			if (clear) begin
				valid_q <= '0;
			end
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						e_q     <= '0;
						state_q <= C_RD;
					end
				end
				C_RD: begin
					state_q <= C_EV;
				end
				C_EV: begin
					e_q <= e_q + CW'(1);
					if (e_q + CW'(1) == capacity) begin
						state_q <= C_WR;
					end else begin
						state_q <= C_RD;
					end
				end
				C_WR: begin
					if (!hit_q) begin
						valid_q[wr_idx] <= 1'b1;
					end
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// per-word search results
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			key_q    <= key;
			nu_q     <= next_use;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			have_v_q <= 1'b0;
			victim_q <= '0;
			far_q    <= '0;
		end else if (state_q == C_EV) begin
			if (valid_q[e_idx]) begin
				if (ekey_rd_q == key_q && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= e_idx;
				end
				if (!have_v_q || enu_rd_q > far_q) begin
					far_q    <= enu_rd_q;
					victim_q <= e_idx;
					have_v_q <= 1'b1;
				end
			end else if (!free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= e_idx;
			end
		end
	end

endmodule

// ===== rtl/belady_optimal_miss_counter.sv =====
// ----------------------------------------------------------------------------
// belady_optimal_miss_counter
// Loads a key trace, links next uses, replays it under optimal replacement.
// ----------------------------------------------------------------------------
// Keys load one per cycle into the trace memory. After the word marked last
// the block accepts nothing until the result is taken: linking walks the
// trace memory (one read port), a read then a compare state per compare,
// up to about n*n/2 compares for a trace of n words; the replay then runs
// each word through the cache unit, which scans its entry memories one
// entry at a time. Words past TRACE_DEPTH are dropped and flagged.
module belady_optimal_miss_counter #(
	parameter int TRACE_DEPTH = bomc_pkg::DEF_TRACE_DEPTH,
	parameter int MAX_ENTRIES = bomc_pkg::DEF_MAX_ENTRIES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bomc_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bomc_pkg::KEY_W-1:0]   key,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [bomc_pkg::COUNT_W-1:0] miss_count,
	output logic                         overflow
);

	localparam int IW = $clog2(TRACE_DEPTH);
	localparam int LW = $clog2(TRACE_DEPTH + 1);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [8:0] {
		S_LOAD   = 9'b000000001,
		S_LI_RD  = 9'b000000010,
		S_LI_WT  = 9'b000000100,
		S_LJ_RD  = 9'b000001000,
		S_LJ_CMP = 9'b000010000,
		S_RP_RD  = 9'b000100000,
		S_RP_WT  = 9'b001000000,
		S_RP_RUN = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t                         state_q;
	logic [bomc_pkg::CAP_W-1:0]     cap_q;
	logic [CW-1:0]                  cap_run_q;
	logic [CW-1:0]                  cap_eff;
	logic [LW-1:0]                  len_q;
	logic                           ovf_q;
	logic [bomc_pkg::COUNT_W-1:0]   misses_q;
	logic [LW-1:0]                  i_q;
	logic [LW-1:0]                  j_q;
	logic [bomc_pkg::KEY_W-1:0]     key_i_q;
	logic [bomc_pkg::KEY_W-1:0]     trace_mem [TRACE_DEPTH];
	logic [LW-1:0]                  nu_mem    [TRACE_DEPTH];
	logic [bomc_pkg::KEY_W-1:0]     trace_rd_q;
	logic [LW-1:0]                  nu_rd_q;
	logic [IW-1:0]                  trace_ra;
	logic                           in_acc;
	logic                           store_we;
	logic                           nu_we;
	logic [LW-1:0]                  nu_wd;
	logic                           match;
	logic                           cache_clear;
	logic                           cache_start;
	bomc_pkg::bomc_rsp_t            cache_rsp;

	assign in_ready   = (state_q == S_LOAD);
	assign out_valid  = (state_q == S_OUT);
	assign miss_count = misses_q;
	assign overflow   = ovf_q;
	assign in_acc     = in_valid && in_ready;
	assign store_we   = in_acc && (len_q < LW'(TRACE_DEPTH));
	assign match      = (trace_rd_q == key_i_q);

	// clamp capacity into 1..MAX_ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (int'(cap_q) > MAX_ENTRIES) begin
			cap_eff = CW'(MAX_ENTRIES);
		end else begin
			cap_eff = CW'(cap_q);
		end
	end

	// trace read address per phase
	always_comb begin
		unique case (state_q)
			S_LJ_RD: trace_ra = j_q[IW-1:0];
			default: trace_ra = i_q[IW-1:0];
		endcase
	end

	// next-use write: match position, or never
	always_comb begin
		nu_we = 1'b0;
		nu_wd = LW'(TRACE_DEPTH);
		if (state_q == S_LJ_RD && j_q == len_q) begin
			nu_we = 1'b1;
		end else if (state_q == S_LJ_CMP && match) begin
			nu_we = 1'b1;
			nu_wd = j_q;
		end
	end

	assign cache_clear = (state_q == S_LI_RD) && (i_q == len_q);
	assign cache_start = (state_q == S_RP_WT);

	// trace and next-use memories
	always_ff @(posedge clk) begin
		if (store_we) begin
			trace_mem[len_q[IW-1:0]] <= key;
		end
		if (nu_we) begin
			nu_mem[i_q[IW-1:0]] <= nu_wd;
		end
		trace_rd_q <= trace_mem[trace_ra];
		nu_rd_q    <= nu_mem[i_q[IW-1:0]];
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bomc_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// hold the key under search
	always_ff @(posedge clk) begin
		if (state_q == S_LI_WT) begin
			key_i_q <= trace_rd_q;
		end
	end

	// load, link, replay, report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			len_q     <= '0;
			ovf_q     <= 1'b0;
			misses_q  <= '0;
			i_q       <= '0;
			j_q       <= '0;
			cap_run_q <= CW'(1);
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (store_we) begin
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							cap_run_q <= cap_eff;
							i_q       <= '0;
							state_q   <= S_LI_RD;
						end
					end
				end
				S_LI_RD: begin
					if (i_q == len_q) begin
						i_q      <= '0;
						misses_q <= '0;
						state_q  <= S_RP_RD;
					end else begin
						state_q <= S_LI_WT;
					end
				end
				S_LI_WT: begin
					j_q     <= i_q + LW'(1);
					state_q <= S_LJ_RD;
				end
				S_LJ_RD: begin
					if (j_q == len_q) begin
						i_q     <= i_q + LW'(1);
						state_q <= S_LI_RD;
					end else begin
						state_q <= S_LJ_CMP;
					end
				end
				S_LJ_CMP: begin
					if (match) begin
						i_q     <= i_q + LW'(1);
						state_q <= S_LI_RD;
					end else begin
						j_q     <= j_q + LW'(1);
						state_q <= S_LJ_RD;
					end
				end
				S_RP_RD: begin
					if (i_q == len_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RP_WT;
					end
				end
				S_RP_WT: begin
					state_q <= S_RP_RUN;
				end
				S_RP_RUN: begin
					if (cache_rsp.done) begin
						if (cache_rsp.miss) begin
							misses_q <= misses_q + bomc_pkg::COUNT_W'(1);
						end
						i_q     <= i_q + LW'(1);
						state_q <= S_RP_RD;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						len_q    <= '0;
						ovf_q    <= 1'b0;
						misses_q <= '0;
						state_q  <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	bomc_cache #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.LW          (LW),
		.CW          (CW)
	) u_cache (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cache_clear),
		.start    (cache_start),
		.key      (trace_rd_q),
		.next_use (nu_rd_q),
		.capacity (cap_run_q),
		.rsp      (cache_rsp)
	);

endmodule

// ===== sim/tb_belady_optimal_miss_counter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_belady_optimal_miss_counter
// Feeds key traces to the optimal-replacement miss counter and checks each
// miss count and overflow flag against a predictor of furthest-next-use
// replacement. A directed table runs first, then random traces at varied
// capacities, one with a long receiver stall, and a trace that overruns the store.
// ----------------------------------------------------------------------------
module tb_belady_optimal_miss_counter;

	localparam int DEPTH   = bomc_pkg::DEF_TRACE_DEPTH;
	localparam int ENTRIES = bomc_pkg::DEF_MAX_ENTRIES;
	localparam int KEY_W   = bomc_pkg::KEY_W;
	localparam int COUNT_W = bomc_pkg::COUNT_W;
	localparam int CAP_W   = bomc_pkg::CAP_W;

	typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [KEY_W-1:0] k;
		logic             lst;
		bit               typed;
		logic [COUNT_W-1:0] cnt;
		logic             ovf;
	} row_t;

	typedef struct packed {
		logic [COUNT_W-1:0] cnt;
		logic               ovf;
	} tally_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CAP_W-1:0]   cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [KEY_W-1:0]   key;
	logic               last;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COUNT_W-1:0] miss_count;
	logic               overflow;

	// predictor state
	logic [KEY_W-1:0] trace_keys[DEPTH];
	int unsigned      next_pos[DEPTH];
	int unsigned      trace_len;
	bit               trace_ovf;
	int unsigned      capacity;

	tally_t tally_q[$];
	int     errors;
	bit     hold_req;
	logic [KEY_W-1:0] key_pool[6];

	belady_optimal_miss_counter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key       (key),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.miss_count(miss_count),
		.overflow  (overflow)
	);

	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// link next uses, then replay with furthest-next-use eviction
	function automatic logic [COUNT_W-1:0] optimal_misses();
		logic [KEY_W-1:0] ent_key[ENTRIES];
		int unsigned      ent_next[ENTRIES];
		bit               ent_valid[ENTRIES];
		int unsigned      cap, hit, free_slot, victim, far, cnt;
		bit               have_victim;
		cap = (capacity == 0) ? 1 : (capacity > ENTRIES ? ENTRIES : capacity);
		for (int i = 0; i < trace_len; i++) begin
			next_pos[i] = DEPTH;
			for (int j = i + 1; j < trace_len; j++)
				if (trace_keys[j] == trace_keys[i]) begin
					next_pos[i] = j;
					break;
				end
		end
		for (int e = 0; e < ENTRIES; e++) ent_valid[e] = 0;
		cnt = 0;
		for (int i = 0; i < trace_len; i++) begin
			hit = cap; free_slot = cap; victim = 0; far = 0; have_victim = 0;
			for (int e = 0; e < cap; e++) begin
				if (ent_valid[e]) begin
					if (ent_key[e] == trace_keys[i] && hit == cap) hit = e;
					if (!have_victim || ent_next[e] > far) begin
						far = ent_next[e]; victim = e; have_victim = 1;
					end
				end else if (free_slot == cap) begin
					free_slot = e;
				end
			end
			if (hit < cap) begin
				ent_next[hit] = next_pos[i];
				continue;
			end
			cnt++;
			if (free_slot == cap) free_slot = victim;
			ent_key[free_slot] = trace_keys[i];
			ent_next[free_slot] = next_pos[i];
			ent_valid[free_slot] = 1;
		end
		return cnt[COUNT_W-1:0];
	endfunction

	// store an accepted word; a last word yields the expected tally
	task automatic absorb_word(input logic [KEY_W-1:0] k, input logic l,
			input bit typed, input tally_t typed_val);
		tally_t t;
		if (trace_len < DEPTH) begin
			trace_keys[trace_len] = k;
			trace_len++;
		end else begin
			trace_ovf = 1;
		end
		if (!l) return;
		t.cnt = optimal_misses();
		t.ovf = trace_ovf;
		tally_q.push_back(typed ? typed_val : t);
		trace_len = 0;
		trace_ovf = 0;
	endtask

	// offer one word after a random gap; leave valid high on return
	task automatic push_word(input logic [KEY_W-1:0] k, input logic l,
			input bit typed = 0, input tally_t typed_val = '0);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key      <= k;
		last     <= l;
		do @(posedge clk); while (!in_ready);
		absorb_word(k, l, typed, typed_val);
	endtask

	// hold off until every expected word has come back, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (tally_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity = 32'(v);
	endtask

	function automatic logic [KEY_W-1:0] random_key();
		return {$urandom, $urandom};
	endfunction

	task automatic random_trace(input int len);
		logic [KEY_W-1:0] k;
		for (int i = 0; i < len; i++) begin
			k = ($urandom_range(0, 5) == 0) ? random_key() : key_pool[$urandom_range(0, 5)];
			push_word(k, i == len - 1);
		end
	endtask

	// receiver: random gaps, plus one long hold on request
	always @(posedge clk or negedge arst_n) begin
		static int gap = 0;
		static int hold = 0;
		tally_t want;
		logic   nxt;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (tally_q.size() == 0) begin
					report($sformatf("unexpected word cnt=%0d ovf=%0b", miss_count, overflow));
				end else begin
					want = tally_q.pop_front();
					if (miss_count !== want.cnt)
						report($sformatf("miss_count %0d, want %0d", miss_count, want.cnt));
					if (overflow !== want.ovf)
						report($sformatf("overflow %0b, want %0b", overflow, want.ovf));
				end
				gap = $urandom_range(0, 4);
			end
			if (hold_req) begin
				hold = 8000;
				hold_req = 0;
			end
			if (hold > 0) begin
				hold--;
				nxt = 1'b0;
			end else if (gap > 0) begin
				gap--;
				nxt = 1'b0;
			end else begin
				nxt = 1'b1;
			end
			out_ready <= nxt;
		end
	end

	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		row_t   rows[$];
		row_t   r;
		tally_t tv;
		int     len;
		errors = 0; hold_req = 0;
		trace_len = 0; trace_ovf = 0; capacity = 32'(bomc_pkg::CAP_RESET);
		arst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
		in_valid = 1'b0; key = '0; last = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: extremes, repeats, capacity clamps
		rows = '{
			'{ROW_WORD, 64'h0, 1, 1, 11'd1, 0},
			'{ROW_WORD, '1, 1, 1, 11'd1, 0},
			'{ROW_WORD, 64'h5, 0, 0, 0, 0},
			'{ROW_WORD, 64'h5, 0, 0, 0, 0},
			'{ROW_WORD, 64'h5, 1, 1, 11'd1, 0},
			'{ROW_WORD, 64'h1, 0, 0, 0, 0},
			'{ROW_WORD, 64'h2, 0, 0, 0, 0},
			'{ROW_WORD, 64'h1, 0, 0, 0, 0},
			'{ROW_WORD, 64'h3, 0, 0, 0, 0},
			'{ROW_WORD, 64'h2, 1, 0, 0, 0},
			'{ROW_CAP, 64'd0, 0, 0, 0, 0},
			'{ROW_WORD, 64'h7, 0, 0, 0, 0},
			'{ROW_WORD, 64'h9, 0, 0, 0, 0},
			'{ROW_WORD, 64'h7, 1, 1, 11'd3, 0},
			'{ROW_CAP, 64'd127, 0, 0, 0, 0},
			'{ROW_WORD, 64'h8000_0000_0000_0000, 0, 0, 0, 0},
			'{ROW_WORD, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0},
			'{ROW_WORD, 64'h8000_0000_0000_0000, 0, 0, 0, 0},
			'{ROW_WORD, 64'h5555_5555_5555_5555, 0, 0, 0, 0},
			'{ROW_WORD, 64'hAAAA_AAAA_AAAA_AAAA, 1, 1, 11'd4, 0},
			'{ROW_CAP, 64'd2, 0, 0, 0, 0},
			'{ROW_WORD, 64'h1, 0, 0, 0, 0},
			'{ROW_WORD, 64'h2, 0, 0, 0, 0},
			'{ROW_WORD, 64'h3, 0, 0, 0, 0},
			'{ROW_WORD, 64'h1, 1, 0, 0, 0}
		};
		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_CAP) begin
				write_capacity(r.k[CAP_W-1:0]);
			end else begin
				tv.cnt = r.cnt;
				tv.ovf = r.ovf;
				push_word(r.k, r.lst, r.typed, tv);
			end
		end

		// random traces over a small key pool at varied capacities
		for (int p = 0; p < 14; p++) begin
			case (p % 7)
				0: write_capacity(7'd1);
				1: write_capacity(7'd64);
				2: write_capacity(7'd0);
				3: write_capacity(7'd127);
				default: write_capacity(CAP_W'($urandom_range(1, 64)));
			endcase
			foreach (key_pool[i]) key_pool[i] = random_key();
			if (p == 3) key_pool[0] = '0;
			if (p == 4) key_pool[0] = '1;
			for (int t = 0; t < 4; t++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
				// long receiver stall while the sender keeps offering
				if (p == 5 && t == 2) hold_req = 1;
				random_trace(len);
			end
		end

		// overrun the store: a small pool keeps linking short
		write_capacity(7'd2);
		foreach (key_pool[i]) key_pool[i] = random_key();
		for (int i = 0; i < DEPTH + 6; i++)
			push_word(key_pool[$urandom_range(0, 3)], i == DEPTH + 5);
		write_capacity(7'd3);
		random_trace(5);

		// wait out the tail
		in_valid <= 1'b0;
		while (tally_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bomc_pkg.sv
rtl/bomc_cache.sv
rtl/belady_optimal_miss_counter.sv
sim/tb_belady_optimal_miss_counter.sv
